// File: sv/rcsfr_pkg.sv
// Shared types, codes and constants of the serial frame receiver.
`default_nettype none

package rcsfr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned IndexW  = 7;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [StatusW-1:0] {
    ST_SKIP    = 3'd0,
    ST_ACCEPT  = 3'd1,
    ST_GOOD    = 3'd2,
    ST_BADTYPE = 3'd3,
    ST_BADLEN  = 3'd4,
    ST_BADCRC  = 3'd5
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SYNC      = 3'd0,
    REG_HANDSHAKE = 3'd1,
    REG_BIND      = 3'd2,
    REG_PARAMETER = 3'd3,
    REG_SIGNAL    = 3'd4,
    REG_TELEMETRY = 3'd5,
    REG_CONTROL   = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [ByteW-1:0] sync_value;
    logic [ByteW-1:0] handshake_type;
    logic [ByteW-1:0] bind_type;
    logic [ByteW-1:0] parameter_type;
    logic [ByteW-1:0] signal_report_type;
    logic [ByteW-1:0] telemetry_type;
    logic [ByteW-1:0] control_type;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    sync_value:         8'd166,
    handshake_type:     8'd33,
    bind_type:          8'd65,
    parameter_type:     8'd80,
    signal_report_type: 8'd85,
    telemetry_type:     8'd128,
    control_type:       8'd205
  };

  // Total frame lengths of the fixed-length packet kinds.
  localparam logic [ByteW-1:0] LEN_HANDSHAKE = 8'd14;
  localparam logic [ByteW-1:0] LEN_BIND      = 8'd21;
  localparam logic [ByteW-1:0] LEN_PARAMETER = 8'd14;
  localparam logic [ByteW-1:0] LEN_SIGNAL    = 8'd10;
  localparam logic [ByteW-1:0] LEN_TELEMETRY = 8'd22;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'h0000;

  typedef struct packed {
    status_e             status;
    logic [ByteW-1:0]    echo_byte;
    logic [IndexW-1:0]   byte_index;
    logic [ByteW-1:0]    frame_type;
    logic [IndexW-1:0]   frame_length;
  } result_t;

  // Fold one byte into a CRC-16, MSB first, no reflection.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [ByteW-1:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: sv/rcsfr_if.sv
// Byte and result channel interfaces of the serial frame receiver.
`default_nettype none

interface rcsfr_byte_if import rcsfr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rcsfr_result_if import rcsfr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [ByteW-1:0]   echo_byte;
  logic [IndexW-1:0]  byte_index;
  logic [ByteW-1:0]   frame_type;
  logic [IndexW-1:0]  frame_length;

  modport source (output valid, output status, output echo_byte, output byte_index,
                  output frame_type, output frame_length, input ready);
  modport sink   (input valid, input status, input echo_byte, input byte_index,
                  input frame_type, input frame_length, output ready);
endinterface

`default_nettype wire

// File: sv/rcsfr_deframer.sv
// Frame state and per-byte decode of the serial frame receiver.
`default_nettype none

module rcsfr_deframer import rcsfr_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = 80,
  parameter int unsigned MIN_FRAME_BYTES = 5
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [ByteW-1:0] rx_byte_i,
  input  wire cfg_t             cfg_i,
  output result_t               res_o
);

  localparam int unsigned CntW = $clog2(MAX_FRAME_BYTES);

  logic [CntW-1:0]  count_q, count_d;
  logic [ByteW-1:0] exp_len_q, exp_len_d;
  logic [ByteW-1:0] type_q, type_d;
  logic [ByteW-1:0] len_field_q, len_field_d;
  logic [15:0]      crc_q, crc_d;
  logic [15:0]      last2_q, last2_d;
  logic             ctrl_q, ctrl_d;

  logic [15:0]      crc_next;
  logic [15:0]      last2_shift;
  logic [ByteW-1:0] type_len;
  logic             type_ok;
  logic             type_ctrl;
  logic [ByteW-1:0] exp_eff;
  logic [ByteW-1:0] lf_eff;
  logic             clear;
  logic             abort;

  assign crc_next    = crc_fold(crc_q, last2_q[15:8]);
  assign last2_shift = {last2_q[7:0], rx_byte_i};

  // Type lookup, first register in order wins.
  always_comb begin
    type_len  = '0;
    type_ok   = 1'b1;
    type_ctrl = 1'b0;
    if (rx_byte_i == cfg_i.handshake_type) begin
      type_len = LEN_HANDSHAKE;
    end else if (rx_byte_i == cfg_i.bind_type) begin
      type_len = LEN_BIND;
    end else if (rx_byte_i == cfg_i.parameter_type) begin
      type_len = LEN_PARAMETER;
    end else if (rx_byte_i == cfg_i.signal_report_type) begin
      type_len = LEN_SIGNAL;
    end else if (rx_byte_i == cfg_i.telemetry_type) begin
      type_len = LEN_TELEMETRY;
    end else if (rx_byte_i == cfg_i.control_type) begin
      type_ctrl = 1'b1;
    end else begin
      type_ok = 1'b0;
    end
  end

  always_comb begin
    count_d     = count_q;
    exp_len_d   = exp_len_q;
    type_d      = type_q;
    len_field_d = len_field_q;
    crc_d       = crc_q;
    last2_d     = last2_q;
    ctrl_d      = ctrl_q;
    exp_eff     = exp_len_q;
    lf_eff      = len_field_q;
    clear       = 1'b0;
    abort       = 1'b0;

    res_o.status       = ST_ACCEPT;
    res_o.echo_byte    = rx_byte_i;
    res_o.byte_index   = IndexW'(count_q);
    res_o.frame_type   = type_q;
    res_o.frame_length = exp_len_q[IndexW-1:0];

    if (count_q == '0) begin
      res_o.frame_type   = '0;
      res_o.frame_length = '0;
      if (rx_byte_i == cfg_i.sync_value) begin
        // Start a fresh frame.
        count_d     = CntW'(1);
        exp_len_d   = '0;
        type_d      = '0;
        len_field_d = '0;
        crc_d       = CRC_INIT;
        last2_d     = {8'h00, rx_byte_i};
        ctrl_d      = 1'b0;
      end else begin
        res_o.status = ST_SKIP;
      end
    end else if (count_q == CntW'(1)) begin
      res_o.frame_type = rx_byte_i;
      if (!type_ok) begin
        res_o.status       = ST_BADTYPE;
        res_o.frame_length = '0;
        clear              = 1'b1;
      end else begin
        type_d             = rx_byte_i;
        exp_len_d          = type_len;
        ctrl_d             = type_ctrl;
        last2_d            = last2_shift;
        count_d            = CntW'(2);
        res_o.frame_length = type_len[IndexW-1:0];
      end
    end else begin
      crc_d   = crc_next;
      last2_d = last2_shift;
      if (count_q == CntW'(2)) begin
        lf_eff      = rx_byte_i;
        len_field_d = rx_byte_i;
        if (ctrl_q) begin
          if (rx_byte_i < ByteW'(MIN_FRAME_BYTES) || rx_byte_i > ByteW'(MAX_FRAME_BYTES)) begin
            abort = 1'b1;
          end else begin
            exp_eff   = rx_byte_i;
            exp_len_d = rx_byte_i;
          end
        end
        res_o.frame_length = exp_eff[IndexW-1:0];
      end
      if (abort) begin
        res_o.status       = ST_BADLEN;
        res_o.frame_length = '0;
        clear              = 1'b1;
      end else if ((9'(count_q) + 9'd1) >= {1'b0, exp_eff}) begin
        // Last byte: length byte first, then the checksum.
        if (lf_eff != exp_eff) begin
          res_o.status = ST_BADLEN;
        end else if (crc_next != last2_shift) begin
          res_o.status = ST_BADCRC;
        end else begin
          res_o.status = ST_GOOD;
        end
        clear = 1'b1;
      end else begin
        count_d = count_q + 1'b1;
      end
    end

    if (clear) begin
      count_d     = '0;
      exp_len_d   = '0;
      type_d      = '0;
      len_field_d = '0;
      crc_d       = CRC_INIT;
      last2_d     = '0;
      ctrl_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      exp_len_q   <= '0;
      type_q      <= '0;
      len_field_q <= '0;
      crc_q       <= CRC_INIT;
      last2_q     <= '0;
      ctrl_q      <= 1'b0;
    end else if (step_i) begin
      count_q     <= count_d;
      exp_len_q   <= exp_len_d;
      type_q      <= type_d;
      len_field_q <= len_field_d;
      crc_q       <= crc_d;
      last2_q     <= last2_d;
      ctrl_q      <= ctrl_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/rc_serial_frame_receiver_unit.sv
// Top level of the serial frame receiver: config registers, byte and result stages.
// Usage:
//   rx_i carries one received byte per transfer (valid/ready, taken when both
//   are high). res_o returns exactly one result per byte: a status code, the
//   byte itself, its index in the frame, the frame type and the expected frame
//   length. Statuses: skipped while hunting, accepted, frame good, bad type,
//   bad length, CRC mismatch (CRC-16 poly 0x1021, init 0, sent big-endian).
//   Registers 0..6 (sync byte and six type bytes) are written through
//   cfg_we_i/cfg_idx_i/cfg_data_i; the user must write them only while no byte
//   is in flight, which the block itself does not enforce. Index 7 is ignored.
// Timing:
//   A byte taken from rx_i is registered in the input stage, decoded against
//   the frame state and registered in the result register, which offers it on
//   res_o. One byte per cycle is sustained while res_o is not stalled, since
//   the decode and CRC fold between the two registers are combinational.
// Reset and stall:
//   Reset restores the default type bytes and puts the receiver into hunting
//   for the sync byte. When res_o is stalled the result register holds, the
//   input stage fills, and rx_i.ready drops only once both are occupied.
`default_nettype none

module rc_serial_frame_receiver_unit import rcsfr_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = 80,
  parameter int unsigned MIN_FRAME_BYTES = 5
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ByteW-1:0]   cfg_data_i,
  rcsfr_byte_if.sink              rx_i,
  rcsfr_result_if.source          res_o
);

  cfg_t             cfg_q;
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_valid_q;
  result_t          res_q;
  result_t          res_d;
  logic             s2_load;
  logic             in_take;

  // Configuration writes; unknown index is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SYNC:      cfg_q.sync_value         <= cfg_data_i;
        REG_HANDSHAKE: cfg_q.handshake_type     <= cfg_data_i;
        REG_BIND:      cfg_q.bind_type          <= cfg_data_i;
        REG_PARAMETER: cfg_q.parameter_type     <= cfg_data_i;
        REG_SIGNAL:    cfg_q.signal_report_type <= cfg_data_i;
        REG_TELEMETRY: cfg_q.telemetry_type     <= cfg_data_i;
        REG_CONTROL:   cfg_q.control_type       <= cfg_data_i;
        default:       cfg_q                    <= cfg_q;
      endcase
    end
  end

  // Advance the decode stage when the input stage holds a byte and the result register is free or drains.
  assign s2_load    = in_valid_q && (!out_valid_q || res_o.ready);
  assign rx_i.ready = !in_valid_q || s2_load;
  assign in_take    = rx_i.valid && rx_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  rcsfr_deframer #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
    .MIN_FRAME_BYTES(MIN_FRAME_BYTES)
  ) u_deframer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s2_load),
    .rx_byte_i(in_byte_q),
    .cfg_i    (cfg_q),
    .res_o    (res_d)
  );

  // Hold the result until the consumer takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.status       = res_q.status;
  assign res_o.echo_byte    = res_q.echo_byte;
  assign res_o.byte_index   = res_q.byte_index;
  assign res_o.frame_type   = res_q.frame_type;
  assign res_o.frame_length = res_q.frame_length;

  // A decoded byte always shows up as a pending result.
  a_load_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_load |=> out_valid_q)
    else $error("decoded byte did not reach the result register");

  // A good frame ends on the byte whose index is one below the expected length.
  a_good_at_last_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.status == ST_GOOD) |->
      (res_q.frame_length == res_q.byte_index + 7'd1))
    else $error("frame reported good before its last byte");

  // Hunting bytes carry no frame context.
  a_skip_is_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.status == ST_SKIP) |->
      (res_q.byte_index == '0 && res_q.frame_type == '0 && res_q.frame_length == '0))
    else $error("skipped byte carries frame state");

endmodule

`default_nettype wire

// File: tb/sv/tb_rc_serial_frame_receiver_unit.sv
// Self-checking testbench of the serial frame receiver: directed and random packet traffic.
`default_nettype none

module tb_rc_serial_frame_receiver_unit;
  import rcsfr_pkg::*;

  // Control length bounds, kept equal to the instance parameters below.
  localparam int unsigned FrameMin = 5;
  localparam int unsigned FrameMax = 80;

  // Register index past the last register; writes to it must be dropped.
  localparam logic [CfgIdxW-1:0] REG_SPARE = 3'd7;

  typedef enum int {
    KIND_HANDSHAKE,
    KIND_BIND,
    KIND_PARAMETER,
    KIND_SIGNAL,
    KIND_TELEMETRY,
    KIND_CONTROL
  } pkt_kind_e;

  // Ways a built packet gets damaged on purpose.
  typedef enum int {
    FLAW_NONE,
    FLAW_CRC,
    FLAW_LEN,
    FLAW_BOTH,
    FLAW_CUT
  } flaw_e;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [ByteW-1:0] cfg_data;

  rcsfr_byte_if   rx_if ();
  rcsfr_result_if res_if ();

  rc_serial_frame_receiver_unit #(
    .MAX_FRAME_BYTES(FrameMax),
    .MIN_FRAME_BYTES(FrameMin)
  ) i_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .rx_i      (rx_if),
    .res_o     (res_if)
  );

  // Mirror of the register file and of the frame assembly state.
  logic [ByteW-1:0]  type_regs [7];
  logic [IndexW-1:0] pos_q;
  logic [ByteW-1:0]  exp_len_q;
  logic [ByteW-1:0]  type_q;
  logic [ByteW-1:0]  len_byte_q;
  logic [15:0]       crc_q;
  logic [15:0]       tail_q;
  logic              ctrl_q;

  // Results still owed by the block, oldest first.
  result_t pending_results [$];

  int src_idle_pct;
  int sink_stall_pct;
  int n_errors;
  int n_bytes;
  int n_frames;
  int n_good;
  int n_badtype;
  int n_badlen;
  int n_badcrc;
  int n_checked;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Bit-serial CRC-16, polynomial 0x1021, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [ByteW-1:0] d);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = ByteW - 1; i >= 0; i--) begin
      fb = r[15] ^ d[i];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  // Drop back to hunting for sync.
  function automatic void clear_frame();
    pos_q      = '0;
    exp_len_q  = '0;
    type_q     = '0;
    len_byte_q = '0;
    crc_q      = CRC_INIT;
    tail_q     = '0;
    ctrl_q     = 1'b0;
  endfunction

  function automatic void load_reset_regs();
    type_regs[REG_SYNC]      = CFG_RESET.sync_value;
    type_regs[REG_HANDSHAKE] = CFG_RESET.handshake_type;
    type_regs[REG_BIND]      = CFG_RESET.bind_type;
    type_regs[REG_PARAMETER] = CFG_RESET.parameter_type;
    type_regs[REG_SIGNAL]    = CFG_RESET.signal_report_type;
    type_regs[REG_TELEMETRY] = CFG_RESET.telemetry_type;
    type_regs[REG_CONTROL]   = CFG_RESET.control_type;
  endfunction

  // Advance the frame state by one received byte and return the result it causes.
  function automatic result_t decode_byte(input logic [ByteW-1:0] b);
    result_t          r;
    logic [ByteW-1:0] len;
    logic             found;
    logic             aborted;
    r.status       = ST_ACCEPT;
    r.echo_byte    = b;
    r.byte_index   = pos_q;
    r.frame_type   = type_q;
    r.frame_length = exp_len_q[IndexW-1:0];
    if (pos_q == 0) begin
      if (b == type_regs[REG_SYNC]) begin
        clear_frame();
        tail_q = {8'h00, b};
        pos_q  = 1;
      end else begin
        r.status = ST_SKIP;
      end
      r.frame_type   = '0;
      r.frame_length = '0;
    end else if (pos_q == 1) begin
      // First matching register wins when several hold the same type.
      found = 1'b1;
      len   = '0;
      if (b == type_regs[REG_HANDSHAKE]) begin
        len = LEN_HANDSHAKE;
      end else if (b == type_regs[REG_BIND]) begin
        len = LEN_BIND;
      end else if (b == type_regs[REG_PARAMETER]) begin
        len = LEN_PARAMETER;
      end else if (b == type_regs[REG_SIGNAL]) begin
        len = LEN_SIGNAL;
      end else if (b == type_regs[REG_TELEMETRY]) begin
        len = LEN_TELEMETRY;
      end else if (b == type_regs[REG_CONTROL]) begin
        ctrl_q = 1'b1;
      end else begin
        found = 1'b0;
      end
      if (!found) begin
        r.status       = ST_BADTYPE;
        r.frame_type   = b;
        r.frame_length = '0;
        clear_frame();
      end else begin
        type_q         = b;
        exp_len_q      = len;
        tail_q         = {tail_q[7:0], b};
        pos_q          = 2;
        r.frame_type   = b;
        r.frame_length = len[IndexW-1:0];
      end
    end else begin
      // The CRC trails the input by two bytes so the checksum itself stays out.
      crc_q   = crc16_byte(crc_q, tail_q[15:8]);
      tail_q  = {tail_q[7:0], b};
      aborted = 1'b0;
      if (pos_q == 2) begin
        len_byte_q = b;
        if (ctrl_q && (b < FrameMin || b > FrameMax)) begin
          r.status       = ST_BADLEN;
          r.frame_length = '0;
          clear_frame();
          aborted = 1'b1;
        end else begin
          if (ctrl_q) begin
            exp_len_q = b;
          end
          r.frame_length = exp_len_q[IndexW-1:0];
        end
      end
      if (!aborted) begin
        if (int'(pos_q) + 1 >= int'(exp_len_q)) begin
          // Length mismatch outranks a CRC mismatch.
          if (len_byte_q != exp_len_q) begin
            r.status = ST_BADLEN;
          end else if (crc_q != tail_q) begin
            r.status = ST_BADCRC;
          end else begin
            r.status = ST_GOOD;
          end
          clear_frame();
        end else begin
          pos_q = pos_q + 1;
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset and time limit
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever begin
      #5 clk = ~clk;
    end
  end

  // Slowest run: roughly 650 bytes, each held off by long idle and stall runs.
  initial begin
    #3000000;
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random stalls and checking
  // ---------------------------------------------------------------------------

  // Drop ready on a share of cycles set by the current phase.
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_if.ready = ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      n_errors++;
    end
  endtask

  // Compare every result transfer against the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: status %0d byte %0d",
               res_if.status, res_if.echo_byte);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        check_field("status", want.status, res_if.status);
        check_field("echo_byte", want.echo_byte, res_if.echo_byte);
        check_field("byte_index", want.byte_index, res_if.byte_index);
        check_field("frame_type", want.frame_type, res_if.frame_type);
        check_field("frame_length", want.frame_length, res_if.frame_length);
        case (want.status)
          ST_GOOD:    n_good++;
          ST_BADTYPE: n_badtype++;
          ST_BADLEN:  n_badlen++;
          ST_BADCRC:  n_badcrc++;
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Byte side and register writes
  // ---------------------------------------------------------------------------

  // Offer one byte; call and return at a falling edge. Insert random idle
  // cycles first, then hold valid until the transfer and record its result.
  task automatic put_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      rx_if.valid   = 1'b0;
      rx_if.rx_byte = $urandom;
      @(negedge clk);
    end
    rx_if.valid   = 1'b1;
    rx_if.rx_byte = b;
    do begin
      @(posedge clk);
    end while (!rx_if.ready);
    pending_results.push_back(decode_byte(b));
    n_bytes++;
    @(negedge clk);
    rx_if.valid = 1'b0;
  endtask

  // Write one register at the next rising edge; index 7 leaves the mirror alone.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] data);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(posedge clk);
    if (idx <= REG_CONTROL) begin
      type_regs[idx] = data;
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Wait for every owed result, then let the two-stage pipeline settle.
  task automatic drain();
    while (pending_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  // Build a packet of the given kind under the current registers and send it.
  // A control length of zero picks one at random, mostly short.
  task automatic send_frame(input pkt_kind_e kind, input flaw_e flaw, input int ctrl_len);
    logic [ByteW-1:0] pkt [$];
    logic [15:0]      crc;
    int               len;
    int               n_send;
    logic [ByteW-1:0] len_byte;
    case (kind)
      KIND_HANDSHAKE: len = LEN_HANDSHAKE;
      KIND_BIND:      len = LEN_BIND;
      KIND_PARAMETER: len = LEN_PARAMETER;
      KIND_SIGNAL:    len = LEN_SIGNAL;
      KIND_TELEMETRY: len = LEN_TELEMETRY;
      default: begin
        if (ctrl_len != 0) begin
          len = ctrl_len;
        end else if ($urandom_range(9) != 0) begin
          len = $urandom_range(FrameMin, 24);
        end else begin
          len = $urandom_range(25, FrameMax);
        end
      end
    endcase
    len_byte = len[ByteW-1:0];
    if (flaw == FLAW_LEN || flaw == FLAW_BOTH) begin
      if (kind == KIND_CONTROL) begin
        len_byte = $urandom_range(1) ? $urandom_range(0, FrameMin - 1)
                                     : $urandom_range(FrameMax + 1, 255);
      end else begin
        len_byte = len_byte ^ $urandom_range(1, 255);
      end
    end
    pkt.push_back(type_regs[REG_SYNC]);
    pkt.push_back(type_regs[int'(REG_HANDSHAKE) + int'(kind)]);
    pkt.push_back(len_byte);
    for (int i = 3; i < len - 2; i++) begin
      pkt.push_back($urandom);
    end
    crc = CRC_INIT;
    foreach (pkt[i]) begin
      crc = crc16_byte(crc, pkt[i]);
    end
    pkt.push_back(crc[15:8]);
    pkt.push_back(crc[7:0]);
    if (flaw == FLAW_CRC || flaw == FLAW_BOTH) begin
      pkt[len - 1 - $urandom_range(1)] ^= $urandom_range(1, 255);
    end
    n_send = (flaw == FLAW_CUT) ? $urandom_range(1, len - 1) : len;
    for (int i = 0; i < n_send; i++) begin
      put_byte(pkt[i]);
    end
    n_frames++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hunting, sync, unknown type, control length bounds, the shortest control
  // packet good and corrupted, and a length error masking a CRC error.
  task automatic test_directed();
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(type_regs[REG_SYNC]);
    put_byte(8'h00);
    put_byte(type_regs[REG_SYNC]);
    put_byte(type_regs[REG_CONTROL]);
    put_byte(FrameMin - 1);
    put_byte(type_regs[REG_SYNC]);
    put_byte(type_regs[REG_CONTROL]);
    put_byte(FrameMax + 1);
    send_frame(KIND_CONTROL, FLAW_NONE, FrameMin);
    send_frame(KIND_CONTROL, FLAW_CRC, FrameMin);
    send_frame(KIND_SIGNAL, FLAW_BOTH, 0);
  endtask

  // Random traffic: mostly well-formed packets with random payload, the rest
  // damaged packets, stray bytes and sync followed by a random type.
  task automatic test_traffic(input int n_items, input int src_pct, input int sink_pct);
    int start;
    int pick;
    int flaw_pick;
    flaw_e flaw;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    start          = n_bytes;
    while (n_bytes - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 4)) put_byte($urandom);
      end else if (pick < 14) begin
        put_byte(type_regs[REG_SYNC]);
        put_byte($urandom);
      end else begin
        flaw_pick = $urandom_range(99);
        if (flaw_pick < 68) begin
          flaw = FLAW_NONE;
        end else if (flaw_pick < 80) begin
          flaw = FLAW_CRC;
        end else if (flaw_pick < 88) begin
          flaw = FLAW_LEN;
        end else if (flaw_pick < 93) begin
          flaw = FLAW_BOTH;
        end else begin
          flaw = FLAW_CUT;
        end
        send_frame(pkt_kind_e'($urandom_range(5)), flaw, 0);
      end
    end
  endtask

  // Extreme register values: sync at zero, types at the byte limits, and a
  // write to the spare index that must change nothing.
  task automatic test_extreme_regs();
    drain();
    write_reg(REG_SYNC, 8'h00);
    write_reg(REG_HANDSHAKE, 8'hFF);
    write_reg(REG_BIND, 8'h01);
    write_reg(REG_PARAMETER, 8'h80);
    write_reg(REG_SIGNAL, 8'h7F);
    write_reg(REG_TELEMETRY, 8'hFE);
    write_reg(REG_CONTROL, 8'h55);
    write_reg(REG_SPARE, 8'hA5);
    test_traffic(120, 64, 0);
  endtask

  // Two registers hold the same type, so the earlier one decides the length;
  // also run the longest control packet once.
  task automatic test_shared_type();
    drain();
    write_reg(REG_SYNC, 8'hFF);
    write_reg(REG_HANDSHAKE, 8'h00);
    write_reg(REG_BIND, 8'h00);
    write_reg(REG_PARAMETER, 8'h02);
    write_reg(REG_SIGNAL, 8'h04);
    write_reg(REG_TELEMETRY, 8'h08);
    write_reg(REG_CONTROL, 8'hFF);
    sink_stall_pct = 64;
    send_frame(KIND_BIND, FLAW_NONE, 0);
    send_frame(KIND_HANDSHAKE, FLAW_NONE, 0);
    send_frame(KIND_CONTROL, FLAW_NONE, FrameMax);
    test_traffic(120, 0, 64);
  endtask

  // Back to the reset register values with idling on both sides.
  task automatic test_reset_regs();
    drain();
    write_reg(REG_SYNC, CFG_RESET.sync_value);
    write_reg(REG_HANDSHAKE, CFG_RESET.handshake_type);
    write_reg(REG_BIND, CFG_RESET.bind_type);
    write_reg(REG_PARAMETER, CFG_RESET.parameter_type);
    write_reg(REG_SIGNAL, CFG_RESET.signal_report_type);
    write_reg(REG_TELEMETRY, CFG_RESET.telemetry_type);
    write_reg(REG_CONTROL, CFG_RESET.control_type);
    test_traffic(120, 23, 23);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    // Drive every input to a known value before reset.
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = REG_SYNC;
    cfg_data       = '0;
    rx_if.valid    = 1'b0;
    rx_if.rx_byte  = '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    n_errors       = 0;
    n_bytes        = 0;
    n_frames       = 0;
    n_good         = 0;
    n_badtype      = 0;
    n_badlen       = 0;
    n_badcrc       = 0;
    n_checked      = 0;
    load_reset_regs();
    clear_frame();

    // Hold reset, then release it at a falling edge.
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_traffic(120, 0, 0);
    test_extreme_regs();
    test_shared_type();
    test_reset_regs();

    drain();
    repeat (8) @(negedge clk);

    $display("Sent %0d bytes in %0d packets over four register settings; %0d results checked.",
             n_bytes, n_frames, n_checked);
    $display("Frames good %0d, bad type %0d, bad length %0d, CRC mismatch %0d.",
             n_good, n_badtype, n_badlen, n_badcrc);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
sv/rcsfr_pkg.sv
sv/rcsfr_if.sv
sv/rcsfr_deframer.sv
sv/rc_serial_frame_receiver_unit.sv
tb/sv/tb_rc_serial_frame_receiver_unit.sv
